// ===== design/aho_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_pkg
// Shared constants, input mode codes and sequencer states for the
// multi-pattern match counter.
// ----------------------------------------------------------------------------
package aho_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int ALPHABET_DEF   = 26;
  localparam int COUNT_BITS_DEF = 16;

  localparam int MODE_W   = 3;
  localparam int SYMBOL_W = 5;
  localparam int OUT_W    = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PAT_LETTER = 3'd0,
    MODE_PAT_END    = 3'd1,
    MODE_BUILD      = 3'd2,
    MODE_TEXT       = 3'd3,
    MODE_TEXT_END   = 3'd4
  } mode_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P_RD,
    ST_P_CHK,
    ST_E_RD,
    ST_E_WR,
    ST_T_RD,
    ST_T_GO,
    ST_W_RD,
    ST_W_CHK,
    ST_V_CLR,
    ST_B1_RD,
    ST_B1_CHK,
    ST_B2_POP,
    ST_B2_U,
    ST_B2_F,
    ST_B2_V,
    ST_B2_VW,
    ST_B2_G
  } state_t;

endpackage

// ===== design/aho_corasick_match_counter_core.sv =====
`timescale 1ns / 1ps
// With links built, a letter outside the alphabet sends the scan back to the root; every text
// letter then walks the fail chain, examining each node, the first visited node included.
// Build: every edge of the root, then each queued trie node in turn, all over the goto port.
// End of text: result registered next cycle, then visit marks cleared over all MAX_NODES nodes.
// After reset a clearing pass over 2**(clog2(MAX_NODES)+clog2(ALPHABET)) goto entries (32768 by
// default) zeroes the tables; no beat is accepted until it ends. Reset is synchronous.
// ----------------------------------------------------------------------------
// aho_corasick_match_counter_core
// Trie loader, breadth-first failure link builder and text scanner that
// counts pattern occurrences, all run by one sequencer over shared RAM ports.
// ----------------------------------------------------------------------------
module aho_corasick_match_counter_core
  import aho_pkg::*;
#(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] symbol
  input  logic [7:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] match_count
  output logic [7:0]  out_tuser   // [0] error
);

  localparam int NB  = $clog2(MAX_NODES);
  localparam int SB  = $clog2(ALPHABET);
  localparam int GAW = NB + SB;
  localparam int CB  = COUNT_BITS;

  state_t state_r, state_nxt;

  logic [NB:0]      node_total_r, node_total_nxt;
  logic [NB-1:0]    cursor_r, cursor_nxt;
  logic [CB-1:0]    total_r, total_nxt;
  logic             built_r, built_nxt;
  logic             err_r, err_nxt;
  logic             dropped_r, dropped_nxt;
  logic [SB-1:0]    sym_r, sym_nxt;
  logic [NB-1:0]    j_r, j_nxt;
  logic [SB-1:0]    i_r, i_nxt;
  logic [NB:0]      head_r, head_nxt;
  logic [NB:0]      tail_r, tail_nxt;
  logic [NB-1:0]    u_r, u_nxt;
  logic [NB-1:0]    f_r, f_nxt;
  logic [NB-1:0]    v_r, v_nxt;
  logic [GAW-1:0]   cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_count_r, out_count_nxt;
  logic             out_err_r, out_err_nxt;

  logic           g_we, f_we, e_we, v_we, q_we;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic [NB-1:0]  g_wdata, g_rdata;
  logic [NB-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
  logic [NB-1:0]  e_waddr, e_raddr;
  logic [CB-1:0]  e_wdata, e_rdata;
  logic [NB-1:0]  v_waddr, v_raddr;
  logic           v_wdata, v_rdata;
  logic [NB-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

  logic           accept;
  mode_t          mode_in;
  logic [SYMBOL_W-1:0] sym_in;
  logic           sym_ok;
  logic           i_last;
  logic           tail_room;
  logic [CB:0]    walk_sum;
  logic [CB:0]    end_inc;

  aho_ram #(.WIDTH(NB), .DEPTH(MAX_NODES << SB)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );
  aho_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );
  aho_ram #(.WIDTH(CB), .DEPTH(MAX_NODES)) u_endc (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  aho_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );
  aho_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign mode_in    = mode_t'(in_tuser[MODE_W-1:0]);
  assign sym_in     = in_tdata[SYMBOL_W-1:0];
  assign sym_ok     = {{(32-SYMBOL_W){1'b0}}, sym_in} < 32'(ALPHABET);
  assign i_last     = (i_r == SB'(ALPHABET - 1));
  assign tail_room  = (tail_r < (NB+1)'(MAX_NODES));
  assign walk_sum   = {1'b0, total_r} + {1'b0, e_rdata};
  assign end_inc    = {1'b0, e_rdata} + (CB+1)'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = {7'd0, out_err_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (cnt_r == {GAW{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (mode_in)
            MODE_PAT_LETTER:
              if (!built_r && !dropped_r && sym_ok) state_nxt = ST_P_RD;
            MODE_PAT_END:
              if (!built_r && !dropped_r) state_nxt = ST_E_RD;
            MODE_BUILD:
              if (!built_r) state_nxt = ST_B1_RD;
            MODE_TEXT:
              if (built_r) state_nxt = sym_ok ? ST_T_RD : ST_W_RD;
            MODE_TEXT_END: state_nxt = ST_V_CLR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_P_RD:   state_nxt = ST_P_CHK;
      ST_P_CHK:  state_nxt = ST_IDLE;
      ST_E_RD:   state_nxt = ST_E_WR;
      ST_E_WR:   state_nxt = ST_IDLE;
      ST_T_RD:   state_nxt = ST_T_GO;
      ST_T_GO:   state_nxt = ST_W_RD;
      ST_W_RD:   state_nxt = ST_W_CHK;
      ST_W_CHK:  state_nxt = (v_rdata || j_r == '0) ? ST_IDLE : ST_W_RD;
      ST_V_CLR:  if (cnt_r[NB-1:0] == NB'(MAX_NODES - 1)) state_nxt = ST_IDLE;
      ST_B1_RD:  state_nxt = ST_B1_CHK;
      ST_B1_CHK: state_nxt = i_last ? ST_B2_POP : ST_B1_RD;
      ST_B2_POP: state_nxt = (head_r == tail_r) ? ST_IDLE : ST_B2_U;
      ST_B2_U:   state_nxt = ST_B2_F;
      ST_B2_F:   state_nxt = ST_B2_V;
      ST_B2_V:   state_nxt = ST_B2_VW;
      ST_B2_VW:  state_nxt = ST_B2_G;
      ST_B2_G:   state_nxt = i_last ? ST_B2_POP : ST_B2_V;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM ports.
  always_comb begin
    node_total_nxt = node_total_r;
    cursor_nxt     = cursor_r;
    total_nxt      = total_r;
    built_nxt      = built_r;
    err_nxt        = err_r;
    dropped_nxt    = dropped_r;
    sym_nxt        = sym_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    u_nxt          = u_r;
    f_nxt          = f_r;
    v_nxt          = v_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_count_nxt  = out_count_r;
    out_err_nxt    = out_err_r;

    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
    v_we = 1'b0; v_waddr = '0; v_wdata = 1'b0; v_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

    unique case (state_r)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = cnt_r;
        if (cnt_r < GAW'(MAX_NODES)) begin
          f_we = 1'b1; f_waddr = cnt_r[NB-1:0];
          e_we = 1'b1; e_waddr = cnt_r[NB-1:0];
          v_we = 1'b1; v_waddr = cnt_r[NB-1:0];
        end
        cnt_nxt = cnt_r + GAW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          sym_nxt = SB'(sym_in);
          case (mode_in)
            MODE_PAT_LETTER: if (built_r) err_nxt = 1'b1;
            MODE_PAT_END: begin
              if (built_r) begin
                err_nxt = 1'b1;
              end else begin
                if (dropped_r) cursor_nxt = '0;
                dropped_nxt = 1'b0;
              end
            end
            MODE_BUILD: begin
              i_nxt    = '0;
              head_nxt = '0;
              tail_nxt = '0;
            end
            MODE_TEXT: begin
              if (!built_r) begin
                err_nxt = 1'b1;
              end else if (!sym_ok) begin
                cursor_nxt = '0;
                j_nxt      = '0;
              end
            end
            MODE_TEXT_END: begin
              out_valid_nxt = 1'b1;
              out_count_nxt = OUT_W'(total_r);
              out_err_nxt   = err_r;
              total_nxt     = '0;
              cnt_nxt       = '0;
              if (built_r) cursor_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_P_RD: g_raddr = {cursor_r, sym_r};
      ST_P_CHK: begin
        if (g_rdata == '0) begin
          if (node_total_r >= (NB+1)'(MAX_NODES)) begin
            err_nxt     = 1'b1;
            dropped_nxt = 1'b1;
          end else begin
            g_we           = 1'b1;
            g_waddr        = {cursor_r, sym_r};
            g_wdata        = node_total_r[NB-1:0];
            cursor_nxt     = node_total_r[NB-1:0];
            node_total_nxt = node_total_r + (NB+1)'(1);
          end
        end else begin
          cursor_nxt = g_rdata;
        end
      end
      ST_E_RD: e_raddr = cursor_r;
      ST_E_WR: begin
        e_we       = 1'b1;
        e_waddr    = cursor_r;
        e_wdata    = end_inc[CB] ? {CB{1'b1}} : end_inc[CB-1:0];
        cursor_nxt = '0;
      end
      ST_T_RD: g_raddr = {cursor_r, sym_r};
      ST_T_GO: begin
        cursor_nxt = g_rdata;
        j_nxt      = g_rdata;
      end
      ST_W_RD: begin
        v_raddr = j_r;
        e_raddr = j_r;
        f_raddr = j_r;
      end
      ST_W_CHK: begin
        // Stop at the first node already counted in this scan, or after the root.
        if (!v_rdata) begin
          v_we      = 1'b1;
          v_waddr   = j_r;
          v_wdata   = 1'b1;
          total_nxt = walk_sum[CB] ? {CB{1'b1}} : walk_sum[CB-1:0];
          j_nxt     = f_rdata;
        end
      end
      ST_V_CLR: begin
        v_we    = 1'b1;
        v_waddr = cnt_r[NB-1:0];
        cnt_nxt = cnt_r + GAW'(1);
      end
      ST_B1_RD: g_raddr = {NB'(0), i_r};
      ST_B1_CHK: begin
        if (g_rdata != '0 && tail_room) begin
          f_we     = 1'b1;
          f_waddr  = g_rdata;
          q_we     = 1'b1;
          q_waddr  = tail_r[NB-1:0];
          q_wdata  = g_rdata;
          tail_nxt = tail_r + (NB+1)'(1);
        end
        i_nxt = i_r + SB'(1);
      end
      ST_B2_POP: begin
        if (head_r == tail_r) begin
          built_nxt   = 1'b1;
          cursor_nxt  = '0;
          dropped_nxt = 1'b0;
        end else begin
          q_raddr  = head_r[NB-1:0];
          head_nxt = head_r + (NB+1)'(1);
        end
      end
      ST_B2_U: begin
        u_nxt   = q_rdata;
        f_raddr = q_rdata;
      end
      ST_B2_F: begin
        f_nxt = f_rdata;
        i_nxt = '0;
      end
      ST_B2_V: g_raddr = {u_r, i_r};
      ST_B2_VW: begin
        v_nxt   = g_rdata;
        g_raddr = {f_r, i_r};
      end
      ST_B2_G: begin
        // A present child takes its link from the parent's fail node; an
        // absent edge is filled from the same place.
        if (v_r != '0) begin
          f_we    = 1'b1;
          f_waddr = v_r;
          f_wdata = g_rdata;
          if (tail_room) begin
            q_we     = 1'b1;
            q_waddr  = tail_r[NB-1:0];
            q_wdata  = v_r;
            tail_nxt = tail_r + (NB+1)'(1);
          end
        end else begin
          g_we    = 1'b1;
          g_waddr = {u_r, i_r};
          g_wdata = g_rdata;
        end
        i_nxt = i_r + SB'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      node_total_r <= (NB+1)'(1);
      cursor_r     <= '0;
      total_r      <= '0;
      built_r      <= 1'b0;
      err_r        <= 1'b0;
      dropped_r    <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      cursor_r     <= cursor_nxt;
      total_r      <= total_nxt;
      built_r      <= built_nxt;
      err_r        <= err_nxt;
      dropped_r    <= dropped_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      i_r          <= i_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    j_r         <= j_nxt;
    u_r         <= u_nxt;
    f_r         <= f_nxt;
    v_r         <= v_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule

// ===== design/aho_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aho_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the match counter. It loads a pattern set that
// fills the trie and overflows it, builds the links, then scans directed and
// random text. An internal automaton predicts every end-of-text total and
// error flag. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import aho_pkg::*;

  localparam int NN   = MAX_NODES_DEF;
  localparam int AB   = ALPHABET_DEF;
  localparam int CMAX = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [15:0] count;
    logic        err;
  } scan_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic [7:0]  in_tuser = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [7:0]  out_tuser;

  aho_corasick_match_counter_core dut (.*);

  always #5 clk = ~clk;

  // Automaton that mirrors the block.
  int unsigned trie_next[NN*AB];
  int unsigned fail_of[NN];
  int unsigned hits_at[NN];
  bit          seen[NN];
  int unsigned bfs_fifo[NN];
  int unsigned node_cnt = 1;
  int unsigned cur_node = 0;
  int unsigned scan_total = 0;
  bit          links_done = 0;
  bit          sticky_err = 0;
  bit          pat_lost = 0;

  scan_res_t   totals_due[$];
  int          tx_idle = 0;
  int          rx_idle = 0;
  logic        rx_hold = 1'b0;
  int          mismatches = 0;

  function automatic int unsigned add_sat(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > CMAX) ? CMAX : int'(s);
  endfunction

  function automatic void build_automaton();
    int unsigned head, tail, u, f, v;
    head = 0;
    tail = 0;
    for (int i = 0; i < AB; i++) begin
      v = trie_next[i];
      if (v != 0 && tail < NN) begin
        fail_of[v] = 0;
        bfs_fifo[tail++] = v;
      end
    end
    while (head < tail) begin
      u = bfs_fifo[head++];
      f = fail_of[u];
      for (int i = 0; i < AB; i++) begin
        v = trie_next[u*AB+i];
        if (v != 0) begin
          fail_of[v] = trie_next[f*AB+i];
          if (tail < NN) bfs_fifo[tail++] = v;
        end else begin
          trie_next[u*AB+i] = trie_next[f*AB+i];
        end
      end
    end
  endfunction

  function automatic void predict(logic [2:0] mode, logic [4:0] sym);
    int unsigned v, j;
    case (mode)
      MODE_PAT_LETTER: begin
        if (links_done) sticky_err = 1;
        else if (!pat_lost && sym < AB) begin
          v = trie_next[cur_node*AB+sym];
          if (v == 0 && node_cnt >= NN) begin
            sticky_err = 1;
            pat_lost = 1;
          end else begin
            if (v == 0) begin
              v = node_cnt++;
              trie_next[cur_node*AB+sym] = v;
            end
            cur_node = v;
          end
        end
      end
      MODE_PAT_END: begin
        if (links_done) sticky_err = 1;
        else begin
          if (!pat_lost) hits_at[cur_node] = add_sat(hits_at[cur_node], 1);
          cur_node = 0;
          pat_lost = 0;
        end
      end
      MODE_BUILD: begin
        if (!links_done) begin
          build_automaton();
          links_done = 1;
          cur_node = 0;
          pat_lost = 0;
        end
      end
      MODE_TEXT: begin
        if (!links_done) sticky_err = 1;
        else begin
          cur_node = (sym >= AB) ? 0 : trie_next[cur_node*AB+sym];
          // Walk the fail chain until a node already counted in this scan, or the root.
          j = cur_node;
          for (int g = 0; g < NN; g++) begin
            if (seen[j]) break;
            seen[j] = 1;
            scan_total = add_sat(scan_total, hits_at[j]);
            if (j == 0) break;
            j = fail_of[j];
          end
        end
      end
      MODE_TEXT_END: begin
        totals_due.push_back('{count: scan_total[15:0], err: sticky_err});
        scan_total = 0;
        seen = '{default: 0};
        if (links_done) cur_node = 0;
      end
      default: ;
    endcase
  endfunction

  // Offers one beat and returns once it has been accepted.
  task automatic send_beat(logic [2:0] mode, logic [4:0] sym);
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {5'd0, mode};
    in_tdata  <= {3'd0, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(mode, sym);
  endtask

  task automatic send_word(string w, logic [2:0] mode);
    for (int i = 0; i < w.len(); i++) send_beat(mode, 5'(w[i] - 8'h61));
  endtask

  task automatic send_pattern(string w);
    send_word(w, MODE_PAT_LETTER);
    send_beat(MODE_PAT_END, 5'd0);
  endtask

  task automatic send_scan(string w);
    send_word(w, MODE_TEXT);
    send_beat(MODE_TEXT_END, 5'd0);
  endtask

  // Stops offering beats, then waits until every result has been checked.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (NN + 64) @(posedge clk);
  endtask

  always @(posedge clk) begin
    scan_res_t want;
    if (out_tvalid && out_tready) begin
      if (totals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: count=%0d error=%0b", out_tdata, out_tuser[0]);
      end else begin
        want = totals_due.pop_front();
        if (out_tdata !== want.count || out_tuser !== {7'd0, want.err}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected count=%0d error=%0b, got count=%0d user=%h",
                     want.count, want.err, out_tdata, out_tuser);
        end
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  // Undefined mode codes and a phase error before any link build, with scan ends that report zero.
  task automatic test_pre_build_items();
    send_beat(MODE_TEXT_END, 5'd0);
    send_beat(3'd5, 5'd31);
    send_beat(3'd6, 5'd0);
    send_beat(3'd7, 5'd17);
    send_beat(MODE_TEXT, 5'd2);
    send_beat(MODE_TEXT_END, 5'd0);
  endtask

  // Classic overlapping set, a duplicate, an empty pattern and a stray symbol.
  task automatic test_directed_patterns();
    send_pattern("he");
    send_pattern("she");
    send_pattern("his");
    send_pattern("hers");
    send_pattern("he");
    send_beat(MODE_PAT_END, 5'd0);
    send_beat(MODE_PAT_LETTER, 5'd7);
    send_beat(MODE_PAT_LETTER, 5'd30);
    send_beat(MODE_PAT_LETTER, 5'd0);
    send_beat(MODE_PAT_END, 5'd0);
  endtask

  // Loads the pattern "z" many times so its end count climbs well above one.
  task automatic test_repeated_pattern();
    for (int i = 0; i < 20; i++) send_pattern("z");
  endtask

  // Random patterns over a..y until the trie is full, then overflow it.
  task automatic test_fill_trie();
    int len;
    int extra;
    extra = 0;
    while (extra < 4) begin
      len = $urandom_range(10, 4);
      for (int i = 0; i < len; i++)
        send_beat(MODE_PAT_LETTER, ($urandom_range(7) == 0 ? 5'($urandom_range(3))
                                                           : 5'($urandom_range(24))));
      send_beat(MODE_PAT_END, 5'd0);
      if (node_cnt >= NN) extra++;
    end
  endtask

  task automatic test_build();
    send_beat(MODE_BUILD, 5'd0);
    send_beat(MODE_PAT_LETTER, 5'd4);
    send_beat(MODE_PAT_END, 5'd0);
    send_beat(MODE_BUILD, 5'd0);
  endtask

  task automatic test_directed_scans();
    send_scan("ushers");
    send_scan("zz");
    send_scan("");
    send_scan("hishe");
    send_beat(MODE_TEXT, 5'd31);
    send_beat(MODE_TEXT, 5'd26);
    send_beat(MODE_TEXT_END, 5'd0);
  endtask

  task automatic send_random_text_item();
    int r;
    r = $urandom_range(99);
    if (r < 3)       send_beat(3'($urandom_range(5, 7)), 5'($urandom_range(31)));
    else if (r < 6)  send_beat(MODE_TEXT, 5'($urandom_range(26, 31)));
    else if (r < 8)  send_beat(3'($urandom_range(2)), 5'($urandom_range(25)));
    else if (r < 16) send_beat(MODE_TEXT_END, 5'($urandom_range(31)));
    else if (r < 60) send_beat(MODE_TEXT, 5'($urandom_range(3)));
    else             send_beat(MODE_TEXT, 5'($urandom_range(24)));
  endtask

  task automatic test_random_scans(int n);
    for (int i = 0; i < n; i++) send_random_text_item();
    send_beat(MODE_TEXT_END, 5'd0);
  endtask

  // The receiver stalls for a long stretch while scan ends keep arriving.
  task automatic test_output_backpressure();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold <= 1'b0;
      end
      for (int i = 0; i < 30; i++) begin
        send_beat(MODE_TEXT, 5'($urandom_range(3)));
        send_beat(MODE_TEXT_END, 5'd0);
      end
    join
  endtask

  initial begin
    tx_idle = 18;
    rx_idle = 63;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_pre_build_items();
    test_directed_patterns();
    test_repeated_pattern();
    test_fill_trie();
    test_build();
    test_directed_scans();
    test_random_scans(60);
    wait_drained();
    tx_idle = 63;
    rx_idle = 18;
    test_output_backpressure();
    test_random_scans(60);
    wait_drained();
    tx_idle = 0;
    rx_idle = 0;
    test_random_scans(60);
    wait_drained();
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
